// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the envelope generator.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock, off while reset is held.
`define AHDSR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Same-cycle implication.
`define AHDSR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define AHDSR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/ahdsr_pkg.sv -----
// Types and constants of the AHDSR envelope generator.
// No dependencies; imported by ahdsr_envelope_generator.
package ahdsr_pkg;

	localparam int DATA_W  = 32;
	localparam int MS_W    = 16;
	localparam int HOLD_W  = 22;
	localparam int STAGE_W = 3;
	localparam int CNT_W   = 5;

	localparam logic [DATA_W-1:0] FULL_SCALE = '1;
	localparam logic [HOLD_W-1:0] HOLD_MAX   = '1;
	localparam logic [CNT_W-1:0]  DIV_LAST   = CNT_W'(DATA_W - 1);

	// Envelope stage codes as seen on the stage output.
	localparam logic [STAGE_W-1:0] ST_OFF     = 3'd0;
	localparam logic [STAGE_W-1:0] ST_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] ST_HOLD    = 3'd2;
	localparam logic [STAGE_W-1:0] ST_DECAY   = 3'd3;
	localparam logic [STAGE_W-1:0] ST_SUSTAIN = 3'd4;
	localparam logic [STAGE_W-1:0] ST_RELEASE = 3'd5;

	// Register indexes on the configuration port.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_ATTACK  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_HOLD    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DECAY   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_RELEASE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LATCH   = 3'd5;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_HOLD_LD = 9'b000000010,
		S_ATK_SET = 9'b000000100,
		S_DEC_SET = 9'b000001000,
		S_REL_SET = 9'b000010000,
		S_DIV     = 9'b000100000,
		S_ADV     = 9'b001000000,
		S_DONE    = 9'b010000000,
		S_SPARE   = 9'b100000000
	} seq_state_t;

	// Which step register takes the quotient.
	typedef enum logic [1:0] {
		DST_ATK = 2'd0,
		DST_DEC = 2'd1,
		DST_REL = 2'd2
	} div_dst_t;

endpackage

// ----- rtl/core/ahdsr_envelope_generator.sv -----
// AHDSR envelope generator: sequencer, shared serial divider and stage logic.
// Depends on ahdsr_pkg and assert_macros.svh.
//
// Usage: each input word is one sample tick carrying the gate level; each
// accepted word yields exactly one output word with the 32-bit level and the
// stage (0 off, 1 attack, 2 hold, 3 decay, 4 sustain, 5 release) after that
// tick. Both channels move a word at an edge where valid is high and stall low.
// Steps after the accept edge, until the output register is loaded:
//   no gate change:                envelope advance
//   gate off starting a release:   release divide, then advance
//   gate on:                       hold load, attack and decay divides, advance
//   latched release out of sustain adds a release divide.
// A zero time skips its divide. One 32-step restoring divider, one quotient bit
// a cycle, computes the attack, decay and release step sizes in turn.
// in_stall is high from the accept edge until the result sits in the output
// register, so one word is in work at a time. A new word is taken while the
// previous result still waits; when the receiver stalls, the finished result
// waits in the sequencer until the output register frees up.
// Reset clears the envelope to off at level zero, the sequencer to idle and all other registers to zero.
// Registers sit at byte addresses 4*i; write them only while the block is idle.
`include "assert_macros.svh"

module ahdsr_envelope_generator #(
	parameter int SAMPLES_PER_MS = 48
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [4:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            gate,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [ahdsr_pkg::DATA_W-1:0]    level,
	output logic [ahdsr_pkg::STAGE_W-1:0]   stage
);
	import ahdsr_pkg::*;

	localparam int NW = MS_W + $clog2(SAMPLES_PER_MS + 1);
	localparam logic [NW-1:0] SPM_C = NW'(SAMPLES_PER_MS);

	// configuration
	logic [MS_W-1:0]   attack_ms_q, hold_ms_q, decay_ms_q, release_ms_q;
	logic [DATA_W-1:0] sustain_level_q;
	logic              latch_mode_q;

	// envelope state
	logic [DATA_W-1:0]  env_level_q, attack_step_q, decay_step_q, release_step_q;
	logic [DATA_W-1:0]  sustain_held_q;
	logic [STAGE_W-1:0] env_stage_q;
	logic [HOLD_W-1:0]  hold_left_q;
	logic               gate_seen_q, latch_pending_q;

	// sequencer and divider
	seq_state_t        state_q;
	div_dst_t          dst_q;
	logic              rel_then_adv_q;
	logic [DATA_W-1:0] num_q;
	logic [NW-1:0]     den_q, rem_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_level_q;
	logic [STAGE_W-1:0] out_stage_q;

	logic                 cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic [MS_W-1:0]      mul_ms;
	logic [NW-1:0]        prod;
	logic [DATA_W-1:0]    hold_ext;
	logic [NW:0]          trial;
	logic                 div_ge;
	logic [NW:0]          div_diff;
	logic [NW-1:0]        rem_next;
	logic [DATA_W-1:0]    num_next;
	logic [DATA_W-1:0]    atk_room;
	logic [DATA_W:0]      dec_sum;
	logic                 atk_go, dec_go, rel_go;
	logic                 out_free;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (cfg_idx)
			REG_ATTACK:  prdata = 32'(attack_ms_q);
			REG_HOLD:    prdata = 32'(hold_ms_q);
			REG_DECAY:   prdata = 32'(decay_ms_q);
			REG_SUSTAIN: prdata = sustain_level_q;
			REG_RELEASE: prdata = 32'(release_ms_q);
			REG_LATCH:   prdata = 32'(latch_mode_q);
			default:     prdata = '0;
		endcase
	end

	// ms to samples; the operand follows the sequencer step
	always_comb begin
		unique case (state_q)
			S_HOLD_LD: mul_ms = hold_ms_q;
			S_ATK_SET: mul_ms = attack_ms_q;
			S_DEC_SET: mul_ms = decay_ms_q;
			default:   mul_ms = release_ms_q;
		endcase
	end
	assign prod     = {{(NW-MS_W){1'b0}}, mul_ms} * SPM_C;
	assign hold_ext = 32'(prod);

	// one restoring divide step
	assign trial    = {rem_q, num_q[DATA_W-1]};
	assign div_diff = trial - {1'b0, den_q};
	assign div_ge   = trial >= {1'b0, den_q};
	assign rem_next = div_ge ? div_diff[NW-1:0] : trial[NW-1:0];
	assign num_next = {num_q[DATA_W-2:0], div_ge};

	assign atk_room = FULL_SCALE - attack_step_q;
	assign atk_go   = (attack_step_q != '0) && (env_level_q < atk_room);
	assign dec_sum  = {1'b0, sustain_held_q} + {1'b0, decay_step_q};
	assign dec_go   = (decay_step_q != '0) && ({1'b0, env_level_q} > dec_sum);
	assign rel_go   = env_level_q > release_step_q;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign level     = out_level_q;
	assign stage     = out_stage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_ms_q     <= '0;
			hold_ms_q       <= '0;
			decay_ms_q      <= '0;
			sustain_level_q <= '0;
			release_ms_q    <= '0;
			latch_mode_q    <= 1'b0;
			env_level_q     <= '0;
			env_stage_q     <= ST_OFF;
			gate_seen_q     <= 1'b0;
			latch_pending_q <= 1'b0;
			attack_step_q   <= '0;
			decay_step_q    <= '0;
			release_step_q  <= '0;
			hold_left_q     <= '0;
			sustain_held_q  <= '0;
			state_q         <= S_IDLE;
			dst_q           <= DST_ATK;
			rel_then_adv_q  <= 1'b0;
			num_q           <= '0;
			den_q           <= '0;
			rem_q           <= '0;
			cnt_q           <= '0;
			out_valid_q     <= 1'b0;
			out_level_q     <= '0;
			out_stage_q     <= ST_OFF;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_ATTACK:  attack_ms_q     <= pwdata[MS_W-1:0];
					REG_HOLD:    hold_ms_q       <= pwdata[MS_W-1:0];
					REG_DECAY:   decay_ms_q      <= pwdata[MS_W-1:0];
					REG_SUSTAIN: sustain_level_q <= pwdata;
					REG_RELEASE: release_ms_q    <= pwdata[MS_W-1:0];
					REG_LATCH:   latch_mode_q    <= pwdata[0];
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && state_q != S_DONE)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (gate != gate_seen_q) begin
							gate_seen_q <= gate;
							if (gate) begin
								state_q <= S_HOLD_LD;
							end else if (!latch_pending_q) begin
								rel_then_adv_q <= 1'b1;
								state_q        <= S_REL_SET;
							end else begin
								state_q <= S_ADV;
							end
						end else begin
							state_q <= S_ADV;
						end
					end
				end
				S_HOLD_LD: begin
					hold_left_q     <= (hold_ext > 32'(HOLD_MAX)) ? HOLD_MAX
						: hold_ext[HOLD_W-1:0];
					sustain_held_q  <= sustain_level_q;
					latch_pending_q <= latch_mode_q;
					env_level_q     <= '0;
					env_stage_q     <= ST_ATTACK;
					state_q         <= S_ATK_SET;
				end
				S_ATK_SET: begin
					if (prod == '0) begin
						attack_step_q <= '0;
						state_q       <= S_DEC_SET;
					end else begin
						den_q   <= prod;
						num_q   <= FULL_SCALE;
						rem_q   <= '0;
						cnt_q   <= '0;
						dst_q   <= DST_ATK;
						state_q <= S_DIV;
					end
				end
				S_DEC_SET: begin
					if (prod == '0) begin
						decay_step_q <= '0;
						state_q      <= S_ADV;
					end else begin
						den_q   <= prod;
						num_q   <= FULL_SCALE - sustain_held_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						dst_q   <= DST_DEC;
						state_q <= S_DIV;
					end
				end
				S_REL_SET: begin
					if (prod == '0) begin
						// zero release time: drop straight to off
						env_level_q <= '0;
						env_stage_q <= ST_OFF;
						state_q     <= rel_then_adv_q ? S_ADV : S_DONE;
					end else begin
						env_stage_q <= ST_RELEASE;
						den_q       <= prod;
						num_q       <= env_level_q;
						rem_q       <= '0;
						cnt_q       <= '0;
						dst_q       <= DST_REL;
						state_q     <= S_DIV;
					end
				end
				S_DIV: begin
					num_q <= num_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST) begin
						unique case (dst_q)
							DST_ATK: begin
								attack_step_q <= num_next;
								state_q       <= S_DEC_SET;
							end
							DST_DEC: begin
								decay_step_q <= num_next;
								state_q      <= S_ADV;
							end
							default: begin
								release_step_q <= num_next;
								state_q        <= rel_then_adv_q ? S_ADV : S_DONE;
							end
						endcase
					end
				end
				S_ADV: begin
					state_q <= S_DONE;
					unique case (env_stage_q)
						ST_ATTACK: begin
							if (atk_go) begin
								env_level_q <= env_level_q + attack_step_q;
							end else begin
								env_level_q <= FULL_SCALE;
								env_stage_q <= ST_HOLD;
							end
						end
						ST_HOLD: begin
							if (hold_left_q == '0)
								env_stage_q <= ST_DECAY;
							else
								hold_left_q <= hold_left_q - 1'b1;
						end
						ST_DECAY: begin
							if (dec_go) begin
								env_level_q <= env_level_q - decay_step_q;
							end else begin
								env_level_q <= sustain_held_q;
								env_stage_q <= ST_SUSTAIN;
							end
						end
						ST_SUSTAIN: begin
							latch_pending_q <= 1'b0;
							// latched gate-off: release now, no further advance
							if (latch_pending_q && !gate_seen_q) begin
								rel_then_adv_q <= 1'b0;
								state_q        <= S_REL_SET;
							end
						end
						ST_RELEASE: begin
							if (rel_go) begin
								env_level_q <= env_level_q - release_step_q;
							end else begin
								env_level_q <= '0;
								env_stage_q <= ST_OFF;
							end
						end
						default: ;
					endcase
				end
				S_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_level_q <= env_level_q;
						out_stage_q <= env_stage_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`AHDSR_ASSERT_IMP(a_div_den_nonzero, state_q == S_DIV, den_q != '0, "divide with zero divisor")
	`AHDSR_ASSERT_IMP(a_out_stage_range, out_valid_q, out_stage_q <= ST_RELEASE, "stage code out of range")
	`AHDSR_ASSERT_IMP(a_off_is_zero, state_q == S_IDLE && env_stage_q == ST_OFF, env_level_q == '0, "level not zero while off")
	`AHDSR_ASSERT_NXT(a_done_loads, state_q == S_DONE && out_free, out_valid_q && state_q == S_IDLE, "result not loaded")
	`AHDSR_ASSERT(a_state_onehot, $onehot(state_q) && state_q != S_SPARE, "sequencer state corrupt")

endmodule
